// ----- hw/rtl/bilinear_downscale_normalize_quantize_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bilinear downscale / normalize / quantize unit
// Clocked on clk_i; the reset-gated form is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_DOWNSCALE_NORMALIZE_QUANTIZE_UNIT_DEFINES_SVH
`define BILINEAR_DOWNSCALE_NORMALIZE_QUANTIZE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BDNQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bdnq: assertion failed");
`define BDNQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("bdnq: assertion failed");
`else
`define BDNQ_ASSERT(lbl, prop)
`define BDNQ_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- hw/rtl/bdnq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdnq_pkg
// Shared types and constants of the downscale / normalize / quantize unit.
// ----------------------------------------------------------------------------
package bdnq_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;
  localparam int PixW     = 24;
  localparam int WgtW     = 16;
  localparam int ShW      = 7;   // right shift amount 56 + exponent

  typedef enum logic [CfgIdxW-1:0] {
    CfgMeanRed   = 3'd0,
    CfgMeanGreen = 3'd1,
    CfgMeanBlue  = 3'd2,
    CfgGainRed   = 3'd3,
    CfgGainGreen = 3'd4,
    CfgGainBlue  = 3'd5,
    CfgQuantExp  = 3'd6
  } cfg_idx_e;

  localparam logic [15:0] MeanRedRst   = 16'd31661;
  localparam logic [15:0] MeanGreenRst = 16'd29768;
  localparam logic [15:0] MeanBlueRst  = 16'd26504;
  localparam logic [23:0] GainRedRst   = 24'd287306;
  localparam logic [23:0] GainGreenRst = 24'd293719;
  localparam logic [23:0] GainBlueRst  = 24'd292413;
  localparam logic [4:0]  QuantExpRst  = 5'd27;   // -5
  localparam logic [ShW-1:0] ShiftBase = 7'd56;

  // controller -> datapath
  typedef struct packed {
    logic accept;   // take the input pixel, read the line store
    logic advance;  // move the destination pointer on
    logic start;    // latch taps and weights into the channel lanes
    logic load;     // write the output register
    logic wr_left;  // line store entry c-1 <= left pixel
    logic wr_cur;   // line store entry c <= current pixel
    logic finish;   // shift left pixel, step source position
  } bdnq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic passed;    // destination pixel lies before the current position
    logic hit;       // current pixel is its lower-right neighbour
    logic out_free;  // output register can take a request
    logic first_col;
    logic last_col;
  } bdnq_sts_t;

endpackage

// ----- hw/rtl/bdnq_axis.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdnq_axis
// Incremental half-pixel coordinate mapper for one axis: taps and Q0.16 weight.
// ----------------------------------------------------------------------------
module bdnq_axis #(
  parameter int SRC = 320,
  parameter int DST = 48
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clear_i,
  input  logic                     step_i,
  output logic [$clog2(SRC)-1:0]   lo_o,
  output logic [$clog2(SRC)-1:0]   hi_o,
  output logic [bdnq_pkg::WgtW-1:0] w_o
);
  import bdnq_pkg::*;

  localparam int Den   = 2 * DST;
  localparam int StepQ = (2 * SRC) / Den;
  localparam int StepR = (2 * SRC) % Den;
  localparam int Num0  = SRC - DST;
  localparam int Q0    = (Num0 >= 0) ? Num0 / Den : -((-Num0 + Den - 1) / Den);
  localparam int R0    = Num0 - Q0 * Den;
  localparam int Wq0   = (R0 * 65536 + DST) / Den;
  localparam int Wr0   = (R0 * 65536 + DST) % Den;
  localparam int WqS   = (StepR * 65536) / Den;
  localparam int WrS   = (StepR * 65536) % Den;
  localparam int CW    = $clog2(SRC);
  localparam int QW    = $clog2(SRC) + 2;
  localparam int RW    = $clog2(Den) + 1;

  logic signed [QW-1:0] q_q, q_d, q_inc;
  logic [RW-1:0]        rem_q, rem_d, rem_sum;
  logic [RW-1:0]        wr_q, wr_d, wr_sum;
  logic [WgtW-1:0]      wq_q, wq_d;
  logic [WgtW:0]        wq_sum;
  logic                 rc, wc;

  always_comb begin
    rem_sum = rem_q + RW'(StepR);
    rc      = rem_sum >= RW'(Den);
    wr_sum  = wr_q + RW'(WrS);
    wc      = wr_sum >= RW'(Den);
    wq_sum  = {1'b0, wq_q} + (WgtW+1)'(WqS) + {{WgtW{1'b0}}, wc};
    q_d     = q_q + QW'(StepQ) + {{(QW-1){1'b0}}, rc};
    rem_d   = rc ? rem_sum - RW'(Den) : rem_sum;
    wr_d    = wc ? wr_sum - RW'(Den) : wr_sum;
    wq_d    = wq_sum[WgtW-1:0];  // a wrap of rem takes 65536 off the weight
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q   <= QW'(Q0);
      rem_q <= RW'(R0);
      wq_q  <= WgtW'(Wq0);
      wr_q  <= RW'(Wr0);
    end else if (clear_i) begin
      q_q   <= QW'(Q0);
      rem_q <= RW'(R0);
      wq_q  <= WgtW'(Wq0);
      wr_q  <= RW'(Wr0);
    end else if (step_i) begin
      q_q   <= q_d;
      rem_q <= rem_d;
      wq_q  <= wq_d;
      wr_q  <= wr_d;
    end
  end

  // clamp both taps to the edge
  always_comb begin
    q_inc = q_q + QW'(1);
    if (q_q < 0) begin
      lo_o = '0;
    end else if (q_q > QW'(SRC - 1)) begin
      lo_o = CW'(SRC - 1);
    end else begin
      lo_o = q_q[CW-1:0];
    end
    if (q_inc < 0) begin
      hi_o = '0;
    end else if (q_inc > QW'(SRC - 1)) begin
      hi_o = CW'(SRC - 1);
    end else begin
      hi_o = q_inc[CW-1:0];
    end
  end

  assign w_o = wq_q;

endmodule

// ----- hw/rtl/bdnq_chan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdnq_chan
// One color lane: bilinear blend, mean/gain normalize, round-even, int8 clamp.
// ----------------------------------------------------------------------------
module bdnq_chan (
  input  logic                      clk_i,
  input  logic [7:0]                p00_i,
  input  logic [7:0]                p01_i,
  input  logic [7:0]                p10_i,
  input  logic [7:0]                p11_i,
  input  logic [bdnq_pkg::WgtW-1:0] wx_i,
  input  logic [bdnq_pkg::WgtW-1:0] wy_i,
  input  logic [15:0]               mean_i,
  input  logic [23:0]               gain_i,
  input  logic [bdnq_pkg::ShW-1:0]  shift_i,
  output logic [7:0]                res_o
);
  import bdnq_pkg::*;

  logic signed [8:0]  d_top, d_bot;
  logic signed [25:0] t_top, t_bot;
  logic [23:0]        top_q, bot_q;
  logic signed [24:0] d_v;
  logic signed [41:0] val, diff;
  logic [39:0]        mag_q;
  logic               neg2_q, neg3_q, neg4_q;
  logic [43:0]        plo_q, phi_q;
  logic [63:0]        prod_q;
  logic [63:0]        sh_full, low_mask;
  logic [5:0]         rb_idx;
  logic               rb, sticky, up;
  logic [24:0]        qv;

  // stage 1: horizontal blend, top = p00 + (p01 - p00) * wx in Q8.16
  always_comb begin
    d_top = $signed({1'b0, p01_i}) - $signed({1'b0, p00_i});
    d_bot = $signed({1'b0, p11_i}) - $signed({1'b0, p10_i});
    t_top = $signed({2'b00, p00_i, 16'h0}) + d_top * $signed({1'b0, wx_i});
    t_bot = $signed({2'b00, p10_i, 16'h0}) + d_bot * $signed({1'b0, wx_i});
  end

  // stage 2: vertical blend in Q8.32, then subtract the mean
  always_comb begin
    d_v  = $signed({1'b0, bot_q}) - $signed({1'b0, top_q});
    val  = $signed({2'b00, top_q, 16'h0}) + d_v * $signed({1'b0, wy_i});
    diff = val - $signed({2'b00, mean_i, 24'h0});
  end

  always_ff @(posedge clk_i) begin
    top_q  <= t_top[23:0];
    bot_q  <= t_bot[23:0];
    neg2_q <= diff[41];
    mag_q  <= diff[41] ? 40'(-diff) : diff[39:0];
    neg3_q <= neg2_q;
    plo_q  <= mag_q[19:0] * gain_i;
    phi_q  <= mag_q[39:20] * gain_i;
    neg4_q <= neg3_q;
    prod_q <= (64'(phi_q) << 20) + 64'(plo_q);
  end

  // shift right by 56 + exponent, round half to even, saturate
  always_comb begin
    sh_full  = prod_q >> shift_i;
    rb_idx   = 6'(shift_i - 7'd1);
    rb       = prod_q[rb_idx];
    low_mask = (64'd1 << rb_idx) - 64'd1;
    sticky   = |(prod_q & low_mask);
    up       = rb && (sticky || sh_full[0]);
    qv       = (shift_i >= 7'd65) ? 25'd0 : sh_full[24:0] + {24'd0, up};
    if (neg4_q) begin
      res_o = (qv > 25'd128) ? 8'h80 : 8'(-qv);
    end else begin
      res_o = (qv > 25'd127) ? 8'h7f : qv[7:0];
    end
  end

endmodule

// ----- hw/rtl/bdnq_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdnq_dpath
// Datapath: config registers, positions, line store, taps, lanes, output reg.
// ----------------------------------------------------------------------------
module bdnq_dpath #(
  parameter int SRC_WIDTH  = 320,
  parameter int SRC_HEIGHT = 240,
  parameter int DST_WIDTH  = 48,
  parameter int DST_HEIGHT = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bdnq_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bdnq_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [bdnq_pkg::PixW-1:0]     in_pix_i,    // blue, green, red from bit 0
  input  logic                          in_fs_i,
  input  bdnq_pkg::bdnq_cmd_t           cmd_i,
  output bdnq_pkg::bdnq_sts_t           sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [39:0]                   out_data_o,
  output logic                          out_last_o
);
  import bdnq_pkg::*;

  localparam int ColW = $clog2(SRC_WIDTH);
  localparam int RowW = $clog2(SRC_HEIGHT);
  localparam int DcW  = $clog2(DST_WIDTH + 1);
  localparam int DrW  = $clog2(DST_HEIGHT + 1);

  logic [15:0] mean_q [3];
  logic [23:0] gain_q [3];
  logic [4:0]  exp_q;
  logic [ShW-1:0] shift;

  logic [ColW-1:0] col_q, col_eff, col_prev;
  logic [RowW-1:0] row_q;
  logic [DcW-1:0]  dcol_q;
  logic [DrW-1:0]  drow_q;
  logic [PixW-1:0] cur_q, left_q, rd_c_q, rd_m_q;
  logic [PixW-1:0] row_mem [SRC_WIDTH];

  logic [ColW-1:0] x0, x1;
  logic [RowW-1:0] y0, y1;
  logic [WgtW-1:0] wx, wy, wx_q, wy_q;
  logic [PixW-1:0] tl, tr, bl, tl_q, tr_q, bl_q, br_q;
  logic [7:0]      res [3];

  logic col_last, row_last, frame_clr, dcol_last, active, xs, ys;
  logic x_clr, x_step, y_step;
  logic [DcW+5:0] dcol_ext;
  logic [DrW+5:0] drow_ext;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q[0] <= MeanRedRst;
      mean_q[1] <= MeanGreenRst;
      mean_q[2] <= MeanBlueRst;
      gain_q[0] <= GainRedRst;
      gain_q[1] <= GainGreenRst;
      gain_q[2] <= GainBlueRst;
      exp_q     <= QuantExpRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgMeanRed:   mean_q[0] <= cfg_data_i[15:0];
        CfgMeanGreen: mean_q[1] <= cfg_data_i[15:0];
        CfgMeanBlue:  mean_q[2] <= cfg_data_i[15:0];
        CfgGainRed:   gain_q[0] <= cfg_data_i;
        CfgGainGreen: gain_q[1] <= cfg_data_i;
        CfgGainBlue:  gain_q[2] <= cfg_data_i;
        CfgQuantExp:  exp_q     <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign shift = ShiftBase + {{2{exp_q[4]}}, exp_q};

  // positions
  assign col_last  = col_q == ColW'(SRC_WIDTH - 1);
  assign row_last  = row_q == RowW'(SRC_HEIGHT - 1);
  assign frame_clr = (cmd_i.accept && in_fs_i) || (cmd_i.finish && col_last && row_last);
  assign dcol_last = dcol_q == DcW'(DST_WIDTH - 1);
  assign active    = drow_q < DrW'(DST_HEIGHT);
  assign x_clr     = frame_clr || (cmd_i.advance && dcol_last);
  assign x_step    = cmd_i.advance && !dcol_last;
  assign y_step    = cmd_i.advance && dcol_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      dcol_q <= '0;
      drow_q <= '0;
      left_q <= '0;
    end else begin
      if (cmd_i.accept && in_fs_i) begin
        col_q <= '0;
        row_q <= '0;
      end else if (cmd_i.finish) begin
        left_q <= cur_q;
        if (col_last) begin
          col_q <= '0;
          row_q <= row_last ? '0 : row_q + RowW'(1);
        end else begin
          col_q <= col_q + ColW'(1);
        end
      end
      if (frame_clr) begin
        dcol_q <= '0;
        drow_q <= '0;
      end else if (cmd_i.advance) begin
        if (dcol_last) begin
          dcol_q <= '0;
          drow_q <= drow_q + DrW'(1);
        end else begin
          dcol_q <= dcol_q + DcW'(1);
        end
      end
    end
  end

  bdnq_axis #(.SRC(SRC_WIDTH), .DST(DST_WIDTH)) u_axis_x (
    .clk_i, .rst_ni, .clear_i(x_clr), .step_i(x_step), .lo_o(x0), .hi_o(x1), .w_o(wx)
  );

  bdnq_axis #(.SRC(SRC_HEIGHT), .DST(DST_HEIGHT)) u_axis_y (
    .clk_i, .rst_ni, .clear_i(frame_clr), .step_i(y_step), .lo_o(y0), .hi_o(y1), .w_o(wy)
  );

  // line store: both reads at accept, writes in the write-back steps
  assign col_eff  = in_fs_i ? '0 : col_q;
  assign col_prev = (col_q == '0) ? '0 : col_q - ColW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_q  <= in_pix_i;
      rd_c_q <= row_mem[col_eff];
      rd_m_q <= row_mem[(col_eff == '0) ? '0 : col_eff - ColW'(1)];
    end
    if (cmd_i.wr_left) begin
      row_mem[col_prev] <= left_q;
    end else if (cmd_i.wr_cur) begin
      row_mem[col_q] <= cur_q;
    end
  end

  // raster compare of the lower-right neighbour against the current pixel
  always_comb begin
    sts_o.passed    = active && ((y1 < row_q) || ((y1 == row_q) && (x1 < col_q)));
    sts_o.hit       = active && (y1 == row_q) && (x1 == col_q);
    sts_o.out_free  = !out_valid_o || out_ready_i;
    sts_o.first_col = col_q == '0;
    sts_o.last_col  = col_last;
  end

  // neighbour selection
  always_comb begin
    ys = y0 == y1;
    xs = (x0 == x1) || (col_q == '0);
    tr = ys ? cur_q : rd_c_q;
    tl = xs ? tr : (ys ? left_q : rd_m_q);
    bl = xs ? cur_q : left_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      tl_q <= tl;
      tr_q <= tr;
      bl_q <= bl;
      br_q <= cur_q;
      wx_q <= wx;
      wy_q <= wy;
    end
  end

  // lane 0 red (pixel bits 23:16), lane 2 blue
  for (genvar k = 0; k < 3; k++) begin : g_lane
    bdnq_chan u_chan (
      .clk_i,
      .p00_i  (tl_q[PixW-1-8*k -: 8]),
      .p01_i  (tr_q[PixW-1-8*k -: 8]),
      .p10_i  (bl_q[PixW-1-8*k -: 8]),
      .p11_i  (br_q[PixW-1-8*k -: 8]),
      .wx_i   (wx_q),
      .wy_i   (wy_q),
      .mean_i (mean_q[k]),
      .gain_i (gain_q[k]),
      .shift_i(shift),
      .res_o  (res[k])
    );
  end

  // output register
  assign dcol_ext = {6'd0, dcol_q};
  assign drow_ext = {6'd0, drow_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_data_o <= {4'd0, drow_ext[5:0], dcol_ext[5:0], res[2], res[1], res[0]};
      out_last_o <= dcol_last && (drow_q == DrW'(DST_HEIGHT - 1));
    end
  end

endmodule

// ----- hw/rtl/bdnq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdnq_ctrl
// Controller: accept, pointer seek, lane run, output load, line store update.
// ----------------------------------------------------------------------------
`include "bilinear_downscale_normalize_quantize_unit_defines.svh"

module bdnq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bdnq_pkg::bdnq_sts_t sts_i,
  output bdnq_pkg::bdnq_cmd_t cmd_o
);
  import bdnq_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StSeek, StCalc, StOut, StWb, StWbLast
  } state_e;

  localparam logic [1:0] CalcLast = 2'd3;  // lane pipeline depth minus one

  state_e     state_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) state_q <= StSeek;
        end
        StSeek: begin
          if (!sts_i.passed) begin
            cnt_q   <= '0;
            state_q <= sts_i.hit ? StCalc : StWb;
          end
        end
        StCalc: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == CalcLast) state_q <= StOut;
        end
        StOut: begin
          if (sts_i.out_free) state_q <= StWb;
        end
        StWb: begin
          state_q <= sts_i.last_col ? StWbLast : StIdle;
        end
        StWbLast: begin
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_comb begin
    in_ready_o    = state_q == StIdle;
    cmd_o.accept  = (state_q == StIdle) && in_valid_i;
    cmd_o.start   = (state_q == StSeek) && !sts_i.passed && sts_i.hit;
    cmd_o.load    = (state_q == StOut) && sts_i.out_free;
    cmd_o.advance = ((state_q == StSeek) && sts_i.passed) || cmd_o.load;
    cmd_o.wr_left = (state_q == StWb) && !sts_i.first_col;
    cmd_o.wr_cur  = state_q == StWbLast;
    cmd_o.finish  = ((state_q == StWb) && !sts_i.last_col) || (state_q == StWbLast);
  end

  `BDNQ_ASSERT(a_load_needs_room, cmd_o.load |-> sts_i.out_free)
  `BDNQ_ASSERT(a_start_not_advance, !(cmd_o.start && cmd_o.advance))
  `BDNQ_ASSERT(a_busy_after_accept, cmd_o.accept |=> !in_ready_o)
  `BDNQ_ASSERT_ALWAYS(a_one_store_write, !(cmd_o.wr_left && cmd_o.wr_cur))

endmodule

// ----- hw/rtl/bilinear_downscale_normalize_quantize_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_downscale_normalize_quantize_unit
// Streaming RGB888 bilinear downscaler with per-channel normalize and int8 out.
// ----------------------------------------------------------------------------
// Sequence: a pixel with no result goes through seek and write-back, with a
//   second write-back step at the last column; one that completes a
//   destination pixel also runs the lanes and loads the output register,
//   waiting while it is not free. Each destination pixel skipped on the way
//   adds a seek step. A new pixel is taken only once the serial controller
//   steps (seek, 4-stage lane pipeline, single line store write port) end.
// Reset: rst_ni clears positions, pointers, config to defaults; line store
//   contents stay undefined and need no clearing pass.
// ----------------------------------------------------------------------------
module bilinear_downscale_normalize_quantize_unit #(
  parameter int SRC_WIDTH  = 320,
  parameter int SRC_HEIGHT = 240,
  parameter int DST_WIDTH  = 48,
  parameter int DST_HEIGHT = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // register write port
  input  logic                          cfg_we_i,
  input  logic [bdnq_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bdnq_pkg::CfgDataW-1:0] cfg_data_i,
  // source pixel stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,  // red, green, blue
  input  logic                          s_axis_tuser,  // frame_start
  // destination pixel stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [39:0]                   m_axis_tdata,  // out_red, out_green,
                                                       // out_blue, dest_x, dest_y
  output logic                          m_axis_tlast   // frame_done
);
  import bdnq_pkg::*;

  bdnq_cmd_t       cmd;
  bdnq_sts_t       sts;
  logic [PixW-1:0] pix;

  // internal pixel word is red in the top byte
  assign pix = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};

  // controller: one request in flight; seeks the destination pointer one
  // step a cycle, runs the lanes, then writes back the line store
  bdnq_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // datapath: output register decouples the result from the next request
  bdnq_dpath #(
    .SRC_WIDTH (SRC_WIDTH),
    .SRC_HEIGHT(SRC_HEIGHT),
    .DST_WIDTH (DST_WIDTH),
    .DST_HEIGHT(DST_HEIGHT)
  ) u_dpath (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_pix_i   (pix),
    .in_fs_i    (s_axis_tuser),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule
